@@ hw/rtl/tgst_pkg.sv @@
// ----------------------------------------------------------------------------
// tgst_pkg
// Shared types and constants of the two-gate speed timer: event codes,
// field widths, scale factors and the job record passed from front to back.
// ----------------------------------------------------------------------------
package tgst_pkg;

	// Event codes carried on the input tuser
	localparam logic [1:0] CMD_GATE_ONE = 2'd0;
	localparam logic [1:0] CMD_GATE_TWO = 2'd1;
	localparam logic [1:0] CMD_BUTTON   = 2'd2;

	// Field widths
	localparam int CMD_W   = 2;
	localparam int TIME_W  = 32;
	localparam int COUNT_W = 32;
	localparam int DIST_W  = 10;
	localparam int SPEED_W = 22;
	localparam int SCALE_W = 12;

	// Divider step counter covers DIST_W steps
	localparam int DIV_CNT_W = 4;

	// Scale factors for the two unit modes
	localparam logic [SCALE_W-1:0] SCALE_MPS = 12'd1000;
	localparam logic [SCALE_W-1:0] SCALE_KMH = 12'd3600;

	// Job queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// One classified event, ready for the speed computation
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [TIME_W-1:0]  interval;
		logic               mode;
		logic               started;
	} job_t;

	// Push side of the job queue
	typedef struct packed {
		logic valid;
		job_t job;
	} job_push_t;

endpackage

@@ hw/rtl/tgst_front.sv @@
// ----------------------------------------------------------------------------
// tgst_front
// Event front end: accepts gate and button beats, keeps the gate-one time
// ring, the slot indexes, the interval, the object count and the mode flags,
// and pushes one job per event into the queue.
// ----------------------------------------------------------------------------
module tgst_front #(
	parameter int SLOT_COUNT = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tgst_pkg::CMD_W-1:0]  in_cmd,
	input  logic [tgst_pkg::TIME_W-1:0] in_time,
	input  logic                        queue_full,
	output tgst_pkg::job_push_t         push
);

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

	logic [tgst_pkg::TIME_W-1:0]  times_q [SLOT_COUNT];
	logic [SLOT_W-1:0]            g1_slot_q;
	logic [SLOT_W-1:0]            g2_slot_q;
	logic [tgst_pkg::TIME_W-1:0]  interval_q;
	logic [tgst_pkg::COUNT_W-1:0] count_q;
	logic                         mode_q;
	logic                         run_q;

	logic                         accept;
	logic [tgst_pkg::TIME_W-1:0]  interval_d;
	logic [tgst_pkg::COUNT_W-1:0] count_d;
	logic                         mode_d;
	logic                         run_d;
	logic                         g1_write;
	logic                         g2_step;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	// Decode the event and work out the new status
	always_comb begin
		interval_d = interval_q;
		count_d    = count_q;
		mode_d     = mode_q;
		run_d      = run_q;
		g1_write   = 1'b0;
		g2_step    = 1'b0;
		unique case (in_cmd)
			tgst_pkg::CMD_GATE_ONE: begin
				g1_write = 1'b1;
			end
			tgst_pkg::CMD_GATE_TWO: begin
				g2_step    = 1'b1;
				interval_d = in_time - times_q[g2_slot_q];
				count_d    = count_q + tgst_pkg::COUNT_W'(1);
			end
			tgst_pkg::CMD_BUTTON: begin
				if (run_q) begin
					mode_d = !mode_q;
				end else begin
					run_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Hold the event state; advance it on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				times_q[i] <= '0;
			end
			g1_slot_q  <= '0;
			g2_slot_q  <= '0;
			interval_q <= tgst_pkg::TIME_W'(1);
			count_q    <= '0;
			mode_q     <= 1'b0;
			run_q      <= 1'b0;
		end else if (accept) begin
			if (g1_write) begin
				times_q[g1_slot_q] <= in_time;
				g1_slot_q <= (g1_slot_q == LAST_SLOT) ? '0 : g1_slot_q + SLOT_W'(1);
			end
			if (g2_step) begin
				g2_slot_q <= (g2_slot_q == LAST_SLOT) ? '0 : g2_slot_q + SLOT_W'(1);
			end
			interval_q <= interval_d;
			count_q    <= count_d;
			mode_q     <= mode_d;
			run_q      <= run_d;
		end
	end

	// Push the updated status as a job
	always_comb begin
		push.valid        = accept;
		push.job.count    = count_d;
		push.job.interval = interval_d;
		push.job.mode     = mode_d;
		push.job.started  = run_d;
	end

endmodule

@@ hw/rtl/tgst_queue.sv @@
// ----------------------------------------------------------------------------
// tgst_queue
// Two-entry job queue that decouples the event front end from the speed
// back end.
// ----------------------------------------------------------------------------
module tgst_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  tgst_pkg::job_push_t push,
	output logic                full,
	output logic                pop_valid,
	input  logic                pop,
	output tgst_pkg::job_t      pop_job
);

	tgst_pkg::job_t                 entries_q [tgst_pkg::QUEUE_DEPTH];
	logic [tgst_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [tgst_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [tgst_pkg::QCNT_W-1:0]    cnt_q;
	logic                           do_push;
	logic                           do_pop;

	assign full      = (cnt_q == tgst_pkg::QCNT_W'(tgst_pkg::QUEUE_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_job   = entries_q[rd_ptr_q];
	assign do_push   = push.valid && !full;
	assign do_pop    = pop && pop_valid;

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push.job;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + tgst_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + tgst_pkg::QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + tgst_pkg::QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - tgst_pkg::QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/tgst_back.sv @@
// ----------------------------------------------------------------------------
// tgst_back
// Speed back end: holds the gate distance, divides it by the interval one
// quotient bit a cycle, scales the quotient and drives the result register.
// ----------------------------------------------------------------------------
module tgst_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [tgst_pkg::DIST_W-1:0]  cfg_wr_data,
	input  logic                         job_valid,
	output logic                         job_pop,
	input  tgst_pkg::job_t               job,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tgst_pkg::COUNT_W-1:0] out_count,
	output logic [tgst_pkg::SPEED_W-1:0] out_speed,
	output logic                         out_mode,
	output logic                         out_started,
	output logic                         out_zero
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	localparam logic [tgst_pkg::DIV_CNT_W-1:0] LAST_STEP =
		tgst_pkg::DIV_CNT_W'(tgst_pkg::DIST_W - 1);

	state_t                          state_q;
	logic [tgst_pkg::DIST_W-1:0]     dist_q;
	logic [tgst_pkg::DIV_CNT_W-1:0]  step_q;
	logic [tgst_pkg::DIST_W-1:0]     dvd_q;
	logic [tgst_pkg::DIST_W-1:0]     rem_q;
	logic [tgst_pkg::DIST_W-1:0]     quot_q;
	logic [tgst_pkg::TIME_W-1:0]     divisor_q;
	logic [tgst_pkg::SPEED_W-1:0]    speed_q;
	tgst_pkg::job_t                  job_q;
	logic                            zero_q;

	logic [tgst_pkg::DIST_W:0]       trial;
	logic                            fits;
	logic [tgst_pkg::SCALE_W-1:0]    scale;
	logic                            out_free;

	// Hold the gate distance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= '0;
		end else if (cfg_wr_en) begin
			dist_q <= cfg_wr_data;
		end
	end

	// Restoring division step
	assign trial = {rem_q, dvd_q[tgst_pkg::DIST_W-1]};
	assign fits  = (tgst_pkg::TIME_W'(trial) >= divisor_q);
	assign scale = job_q.mode ? tgst_pkg::SCALE_KMH : tgst_pkg::SCALE_MPS;

	assign out_free = !out_valid || out_ready;
	assign job_pop  = (state_q == ST_IDLE) && job_valid;

	// Sequence one job: divide (skipped when the interval is zero), scale, deliver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						step_q  <= '0;
						state_q <= (job.interval == '0) ? ST_MUL : ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + tgst_pkg::DIV_CNT_W'(1);
					if (step_q == LAST_STEP) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the divider and scaler
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job_valid) begin
			job_q     <= job;
			zero_q    <= (job.interval == '0);
			divisor_q <= job.interval;
			dvd_q     <= dist_q;
			rem_q     <= '0;
			quot_q    <= '0;
		end
		if (state_q == ST_DIV) begin
			dvd_q  <= {dvd_q[tgst_pkg::DIST_W-2:0], 1'b0};
			rem_q  <= fits ? trial[tgst_pkg::DIST_W-1:0] - divisor_q[tgst_pkg::DIST_W-1:0]
			               : trial[tgst_pkg::DIST_W-1:0];
			quot_q <= {quot_q[tgst_pkg::DIST_W-2:0], fits};
		end
		if (state_q == ST_MUL) begin
			speed_q <= tgst_pkg::SPEED_W'(quot_q) * tgst_pkg::SPEED_W'(scale);
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_count   <= job_q.count;
			out_speed   <= zero_q ? '0 : speed_q;
			out_mode    <= job_q.mode;
			out_started <= job_q.started;
			out_zero    <= zero_q;
		end
	end

endmodule

@@ hw/rtl/two_gate_speed_timer_top.sv @@
// A result follows its accepted event beat through the job queue, the serial divider
// (skipped when the interval is zero), the scaling step and the output register, and may wait there on the output.
// The back end takes one event at a time, paced by its 10-step serial divider; a
// two-entry queue lets the front take events while the back works.
// Reset (arst_n low, asynchronous) clears the time ring, slots, count, mode and
// started flag, sets the interval to one and the gate distance to zero.
// ----------------------------------------------------------------------------
// two_gate_speed_timer_top
// Light gate speed timer: pairs gate-one and gate-two events, counts objects
// and reports the speed in one of two unit modes.
// ----------------------------------------------------------------------------
module two_gate_speed_timer_top #(
	parameter int SLOT_COUNT = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [9:0]  cfg_wr_data,    // gate_distance_cm
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,        // [31:0] event_time_ms
	input  logic [1:0]  s_tuser,        // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,        // [31:0] object_count, [53:32] speed_value,
	                                    // [54] started_flag, [55] zero_interval
	output logic        m_tuser         // [0] unit_mode
);

	tgst_pkg::job_push_t          push;
	tgst_pkg::job_t               pop_job;
	logic                         queue_full;
	logic                         pop_valid;
	logic                         pop;
	logic [tgst_pkg::COUNT_W-1:0] out_count;
	logic [tgst_pkg::SPEED_W-1:0] out_speed;
	logic                         out_started;
	logic                         out_zero;

	tgst_front #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_cmd     (s_tuser),
		.in_time    (s_tdata),
		.queue_full (queue_full),
		.push       (push)
	);

	tgst_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (queue_full),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_job   (pop_job)
	);

	tgst_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.job_valid   (pop_valid),
		.job_pop     (pop),
		.job         (pop_job),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_count   (out_count),
		.out_speed   (out_speed),
		.out_mode    (m_tuser),
		.out_started (out_started),
		.out_zero    (out_zero)
	);

	// Pack the result beat
	assign m_tdata = {out_zero, out_started, out_speed, out_count};

endmodule
